// ===== rtl/pipr_pkg.sv =====
package pipr_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 31;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MARK_W       = 2;
    localparam int WORD_W       = MARK_W + 2 * COORD_BITS;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int EXT_W        = DIFF_W + 1;
    localparam int WIDE_W       = 2 * EXT_W;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam int MARK_RING_BIT = 0;
    localparam int MARK_POLY_BIT = 1;

endpackage

// ===== rtl/point_in_polygon_ray_cast_top.sv =====
// Point-in-multipolygon test by even-odd ray casting over a stored vertex list.
// A word is offered on kind, coord_x, coord_y, starts_ring and starts_polygon
// with start high; it is taken at a clock edge where busy is low.
// A clear or an append word answers in the next cycle with a one-cycle done
// pulse; status is 1 when an append found the store full and dropped the vertex.
// A query reads one stored vertex per cycle from the vertex memory and keeps
// busy high the whole time until it answers; each vertex passes through the
// memory read, the edge pipeline stages s2, s3 and s4, and the final check.
// within_res holds the answer while done is high and is 0 for other words.
// true_on_boundary picks the answer of a polygon whose edge holds the point;
// the user must write it through cfg_write and cfg_data only while the block is idle, which the block does not enforce.
// Results cannot be held off: each is shown for exactly the one done cycle.
// Reset empties the vertex list and clears true_on_boundary; the memory
// itself is not cleared and needs no clearing pass.
module point_in_polygon_ray_cast_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic signed [pipr_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [pipr_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                 starts_ring,
    input  logic                                 starts_polygon,
    output logic                                 done,
    output logic                                 within_res,
    output logic                                 status,
    input  logic                                 cfg_write,
    input  logic                                 cfg_data
);

    localparam int CB = pipr_pkg::COORD_BITS;
    localparam int DW = pipr_pkg::DIFF_W;
    localparam int PW = pipr_pkg::PROD_W;
    localparam int EW = pipr_pkg::EXT_W;
    localparam int WW = pipr_pkg::WIDE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_t;

    logic [pipr_pkg::WORD_W-1:0] mem [pipr_pkg::MAX_VERTICES];
    logic [pipr_pkg::WORD_W-1:0] mem_q;

    state_t state_reg;
    logic [pipr_pkg::CNT_W-1:0] count_reg;
    logic [pipr_pkg::CNT_W-1:0] idx_reg;
    logic tob_reg;
    logic done_reg, within_reg, status_reg;
    logic signed [CB-1:0] px_reg, py_reg;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg;

    logic s1_v_reg, s1_first_reg;
    logic s2_v_reg, s2_first_reg, s2_edge_reg, s2_pstart_reg, s2_cond_reg, s2_sgn_reg;
    logic signed [DW-1:0] s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg;
    logic signed [DW-1:0] s2_dx_reg, s2_dyp_reg, s2_d_reg, s2_t_reg;
    logic s3_v_reg, s3_first_reg, s3_edge_reg, s3_pstart_reg, s3_cond_reg, s3_sgn_reg;
    logic s3_dneg_reg;
    logic signed [PW-1:0] s3_p1_reg, s3_p2_reg, s3_n_reg;
    logic signed [EW-1:0] s3_dabs_reg, s3_s_reg;
    logic s4_v_reg, s4_first_reg, s4_edge_reg, s4_pstart_reg, s4_cond_reg, s4_sgn_reg;
    logic s4_zero_reg;
    logic signed [PW-1:0] s4_nn_reg;
    logic signed [WW-1:0] s4_m_reg;
    logic signed [EW-1:0] s4_dabs_reg;
    logic any_reg, bnd_reg, par_reg;

    logic accept;
    logic signed [CB-1:0] cur_x, cur_y;
    logic [pipr_pkg::MARK_W-1:0] cur_mark;
    logic cur_edge, cur_pstart;
    logic signed [DW-1:0] x1, y1, x2, y2, dx, dyp, dd, tt;
    logic sgn_ok, cond;
    logic signed [EW-1:0] d_ext, t_ext;
    logic signed [WW-1:0] nn_w, dabs_w;
    logic ge, cross_now, onedge_now, pol_ans, final_ans;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign within_res = within_reg;
    assign status     = status_reg;

    always_ff @(posedge clk)
    begin
        if (accept && kind == pipr_pkg::KIND_APPEND && count_reg < pipr_pkg::MAX_VERTICES)
        begin
            mem[count_reg[pipr_pkg::ADDR_W-1:0]] <=
                {starts_polygon, starts_ring | starts_polygon, coord_y, coord_x};
        end
        mem_q <= mem[idx_reg[pipr_pkg::ADDR_W-1:0]];
    end

    always_comb
    begin
        cur_x    = mem_q[CB-1:0];
        cur_y    = mem_q[2*CB-1:CB];
        cur_mark = mem_q[pipr_pkg::WORD_W-1:2*CB];
        cur_pstart = s1_first_reg || cur_mark[pipr_pkg::MARK_POLY_BIT];
        cur_edge   = !s1_first_reg && (cur_mark == '0);
        x1  = DW'(px_reg) - DW'(prev_x_reg);
        y1  = DW'(py_reg) - DW'(prev_y_reg);
        x2  = DW'(px_reg) - DW'(cur_x);
        y2  = DW'(py_reg) - DW'(cur_y);
        dx  = DW'(cur_x) - DW'(prev_x_reg);
        dyp = y1;
        dd  = DW'(cur_y) - DW'(prev_y_reg);
        tt  = x1;
        sgn_ok = (x1 == 0 || x2 == 0 || x1[DW-1] != x2[DW-1])
              && (y1 == 0 || y2 == 0 || y1[DW-1] != y2[DW-1]);
        cond = (prev_y_reg > py_reg) != (cur_y > py_reg);
        d_ext = EW'(s2_d_reg);
        t_ext = EW'(s2_t_reg);
        nn_w   = WW'(s4_nn_reg);
        dabs_w = WW'(s4_dabs_reg);
        if (!s4_nn_reg[PW-1])
        begin
            ge = nn_w >= s4_m_reg;
        end
        else
        begin
            ge = nn_w > s4_m_reg - dabs_w;
        end
        cross_now  = s4_cond_reg && ge;
        onedge_now = s4_zero_reg && s4_sgn_reg;
        pol_ans    = bnd_reg ? tob_reg : par_reg;
        final_ans  = any_reg || ((count_reg != 0) && pol_ans);
    end

    always_ff @(posedge clk)
    begin
        s2_x1_reg  <= x1;
        s2_y1_reg  <= y1;
        s2_x2_reg  <= x2;
        s2_y2_reg  <= y2;
        s2_dx_reg  <= dx;
        s2_dyp_reg <= dyp;
        s2_d_reg   <= dd;
        s2_t_reg   <= tt;
        s2_cond_reg <= cond;
        s2_sgn_reg  <= sgn_ok;
        s2_edge_reg   <= cur_edge;
        s2_pstart_reg <= cur_pstart;
        s2_first_reg  <= s1_first_reg;

        s3_p1_reg <= s2_x1_reg * s2_y2_reg;
        s3_p2_reg <= s2_x2_reg * s2_y1_reg;
        s3_n_reg  <= s2_dx_reg * s2_dyp_reg;
        s3_dneg_reg <= s2_d_reg[DW-1];
        s3_dabs_reg <= s2_d_reg[DW-1] ? -d_ext : d_ext;
        s3_s_reg    <= t_ext + EW'(1);
        s3_cond_reg <= s2_cond_reg;
        s3_sgn_reg  <= s2_sgn_reg;
        s3_edge_reg   <= s2_edge_reg;
        s3_pstart_reg <= s2_pstart_reg;
        s3_first_reg  <= s2_first_reg;

        s4_zero_reg <= (s3_p1_reg == s3_p2_reg);
        s4_nn_reg   <= s3_dneg_reg ? -s3_n_reg : s3_n_reg;
        s4_m_reg    <= s3_s_reg * s3_dabs_reg;
        s4_dabs_reg <= s3_dabs_reg;
        s4_cond_reg <= s3_cond_reg;
        s4_sgn_reg  <= s3_sgn_reg;
        s4_edge_reg   <= s3_edge_reg;
        s4_pstart_reg <= s3_pstart_reg;
        s4_first_reg  <= s3_first_reg;

        if (s1_v_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            tob_reg    <= 1'b0;
            done_reg   <= 1'b0;
            within_reg <= 1'b0;
            status_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            any_reg    <= 1'b0;
            bnd_reg    <= 1'b0;
            par_reg    <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            within_reg <= 1'b0;
            status_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= s1_v_reg;
            s3_v_reg   <= s2_v_reg;
            s4_v_reg   <= s3_v_reg;
            if (cfg_write)
            begin
                tob_reg <= cfg_data;
            end
            if (s4_v_reg)
            begin
                if (s4_pstart_reg)
                begin
                    if (!s4_first_reg)
                    begin
                        any_reg <= any_reg || pol_ans;
                    end
                    bnd_reg <= 1'b0;
                    par_reg <= 1'b0;
                end
                else if (s4_edge_reg)
                begin
                    if (onedge_now)
                    begin
                        bnd_reg <= 1'b1;
                    end
                    else if (cross_now)
                    begin
                        par_reg <= !par_reg;
                    end
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        priority case (kind)
                            pipr_pkg::KIND_CLEAR:
                            begin
                                count_reg <= '0;
                                done_reg  <= 1'b1;
                            end
                            pipr_pkg::KIND_APPEND:
                            begin
                                done_reg <= 1'b1;
                                if (count_reg < pipr_pkg::MAX_VERTICES)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    status_reg <= 1'b1;
                                end
                            end
                            pipr_pkg::KIND_QUERY:
                            begin
                                idx_reg   <= '0;
                                any_reg   <= 1'b0;
                                bnd_reg   <= 1'b0;
                                par_reg   <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg < count_reg)
                    begin
                        s1_v_reg     <= 1'b1;
                        s1_first_reg <= (idx_reg == 0);
                        idx_reg      <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_v_reg && !s2_v_reg && !s3_v_reg && !s4_v_reg)
                    begin
                        done_reg   <= 1'b1;
                        within_reg <= final_ans;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted word neither answered nor started a scan");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pipr_pkg::MAX_VERTICES)
        else $error("vertex count beyond store depth");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg))
        else $error("edge pipeline busy while idle");
    a_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> !within_res)
        else $error("full status together with a query answer");
`endif

endmodule
